// ===== hdl/rpst_pkg.sv =====
// rpst_pkg: shared types and codes for the random pick set table.
// Operation codes, status codes and the sequencer state type.
// No dependencies.
`default_nettype none

package rpst_pkg;

	localparam int RND_W  = 16;
	localparam int VAL_W  = 32;
	localparam int STEP_W = 5;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_PICK   = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_MISS  = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MV_RD,
		S_MV_WR,
		S_PICK,
		S_DIV,
		S_PK_OUT
	} state_t;

endpackage

`default_nettype wire

// ===== hdl/random_pick_set_table.sv =====
// random_pick_set_table: set of distinct 32-bit values in a dense store with
// linear search, swap-with-last remove and random pick. Uses rpst_pkg, rpst_mod.
//
//  channel   handshake           payload
//  command   start / busy        operation, item_value, random_word
//  result    done (1-cycle)      success, picked_value, status
//
// Insert and remove scan the store one entry per cycle through the single
// memory read port; a remove that hits then reads the last entry and writes it
// into the hole. A pick runs the 16-step remainder unit, then one read.
// busy is high from accept until the result is registered; done rises with
// the result as busy falls and cannot be held off. Reset clears the count;
// store contents need no reset since only entries below the count are read.
`default_nettype none

module random_pick_set_table #(
	parameter int CAPACITY = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [1:0]                  operation,
	input  wire logic signed [31:0]          item_value,
	input  wire logic [15:0]                 random_word,
	output logic                             done,
	output logic                             success,
	output logic signed [31:0]               picked_value,
	output logic [1:0]                       status
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int VAL_W = rpst_pkg::VAL_W;

	rpst_pkg::state_t state_q, state_d;

	logic [1:0]       op_q;
	logic [VAL_W-1:0] val_q;
	logic [15:0]      rnd_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_q;
	logic [CNT_W-1:0] cnt_m1;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic [IDX_W-1:0] pos_q;
	logic [VAL_W-1:0] rdata_q;

	logic [VAL_W-1:0] mem [CAPACITY];

	logic             done_q;
	logic             success_q;
	logic [VAL_W-1:0] picked_q;
	logic [1:0]       status_q;

	logic             accept;
	logic             hit;
	logic             scan_more;
	logic             is_ins;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [VAL_W-1:0] mem_wdata;
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;
	logic             res_load;
	logic             res_success;
	logic [1:0]       res_status;
	logic [VAL_W-1:0] res_picked;
	logic             cnt_inc;
	logic             cnt_dec;
	logic             scan_adv;
	logic             div_start;
	logic             div_done;
	logic [IDX_W-1:0] div_rem;

	assign busy      = (state_q != rpst_pkg::S_IDLE);
	assign accept    = start && !busy;
	assign is_ins    = (op_q == rpst_pkg::OP_INSERT);
	assign scan_more = (scan_q < count_q);
	assign cnt_m1    = count_q - CNT_W'(1);
	assign hit       = (state_q == rpst_pkg::S_SCAN) && cmp_vld_s1 && (rdata_q == val_q);
	assign scan_adv  = mem_re && (state_q == rpst_pkg::S_SCAN);

	rpst_mod #(
		.CAPACITY (CAPACITY)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (rnd_q),
		.divisor   (count_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			rpst_pkg::S_IDLE: begin
				if (accept) begin
					if (operation == rpst_pkg::OP_INSERT || operation == rpst_pkg::OP_REMOVE)
						state_d = rpst_pkg::S_SCAN;
					else
						state_d = rpst_pkg::S_PICK;
				end
			end
			rpst_pkg::S_SCAN: begin
				if (hit)
					state_d = is_ins ? rpst_pkg::S_IDLE : rpst_pkg::S_MV_RD;
				else if (!scan_more)
					state_d = rpst_pkg::S_IDLE;
			end
			rpst_pkg::S_MV_RD:  state_d = rpst_pkg::S_MV_WR;
			rpst_pkg::S_MV_WR:  state_d = rpst_pkg::S_IDLE;
			rpst_pkg::S_PICK: begin
				state_d = (count_q == '0) ? rpst_pkg::S_IDLE : rpst_pkg::S_DIV;
			end
			rpst_pkg::S_DIV: begin
				if (div_done)
					state_d = rpst_pkg::S_PK_OUT;
			end
			rpst_pkg::S_PK_OUT: state_d = rpst_pkg::S_IDLE;
			default:            state_d = rpst_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		mem_we      = 1'b0;
		mem_waddr   = '0;
		mem_wdata   = val_q;
		mem_re      = 1'b0;
		mem_raddr   = '0;
		res_load    = 1'b0;
		res_success = 1'b0;
		res_status  = rpst_pkg::ST_DONE;
		res_picked  = '0;
		cnt_inc     = 1'b0;
		cnt_dec     = 1'b0;
		div_start   = 1'b0;
		case (state_q)
			rpst_pkg::S_SCAN: begin
				if (hit) begin
					if (is_ins) begin
						res_load   = 1'b1;
						res_status = rpst_pkg::ST_MISS;
					end
				end else if (scan_more) begin
					mem_re    = 1'b1;
					mem_raddr = scan_q[IDX_W-1:0];
				end else begin
					res_load = 1'b1;
					if (!is_ins) begin
						res_status = rpst_pkg::ST_MISS;
					end else if (count_q >= CNT_W'(CAPACITY)) begin
						res_status = rpst_pkg::ST_FULL;
					end else begin
						mem_we      = 1'b1;
						mem_waddr   = count_q[IDX_W-1:0];
						cnt_inc     = 1'b1;
						res_success = 1'b1;
					end
				end
			end
			rpst_pkg::S_MV_RD: begin
				// fetch the last entry to fill the hole
				mem_re    = 1'b1;
				mem_raddr = cnt_m1[IDX_W-1:0];
			end
			rpst_pkg::S_MV_WR: begin
				mem_we      = 1'b1;
				mem_waddr   = pos_q;
				mem_wdata   = rdata_q;
				cnt_dec     = 1'b1;
				res_load    = 1'b1;
				res_success = 1'b1;
			end
			rpst_pkg::S_PICK: begin
				if (count_q == '0) begin
					res_load   = 1'b1;
					res_status = rpst_pkg::ST_EMPTY;
				end else begin
					div_start = 1'b1;
				end
			end
			rpst_pkg::S_DIV: begin
				if (div_done) begin
					mem_re    = 1'b1;
					mem_raddr = div_rem;
				end
			end
			rpst_pkg::S_PK_OUT: begin
				res_load    = 1'b1;
				res_success = 1'b1;
				res_picked  = rdata_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rpst_pkg::S_IDLE;
			count_q    <= '0;
			scan_q     <= '0;
			cmp_vld_s1 <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= scan_adv;
			done_q     <= res_load;
			if (accept)
				scan_q <= '0;
			else if (scan_adv)
				scan_q <= scan_q + CNT_W'(1);
			if (cnt_inc)
				count_q <= count_q + CNT_W'(1);
			else if (cnt_dec)
				count_q <= cnt_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			val_q <= item_value;
			rnd_q <= random_word;
		end
		if (scan_adv)
			cmp_idx_s1 <= scan_q[IDX_W-1:0];
		// hold the slot of the match for the move
		if (hit)
			pos_q <= cmp_idx_s1;
		if (res_load) begin
			success_q <= res_success;
			status_q  <= res_status;
			picked_q  <= res_picked;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rdata_q <= mem[mem_raddr];
	end

	assign done         = done_q;
	assign success      = success_q;
	assign status       = status_q;
	assign picked_value = $signed(picked_q);

endmodule

`default_nettype wire

// ===== hdl/rpst_mod.sv =====
// rpst_mod: restoring remainder unit, one quotient bit per cycle.
// Computes dividend % divisor for the pick index; uses rpst_pkg.
`default_nettype none

module rpst_mod #(
	parameter int CAPACITY = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic [rpst_pkg::RND_W-1:0]            dividend,
	input  wire logic [$clog2(CAPACITY+1)-1:0]         divisor,
	output logic                                       done,
	output logic [$clog2(CAPACITY)-1:0]                remainder
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);

	logic                              run_q;
	logic                              done_q;
	logic [rpst_pkg::STEP_W-1:0]       step_q;
	logic [rpst_pkg::RND_W-1:0]        quo_q;
	logic [CNT_W-1:0]                  rem_q;
	logic [CNT_W:0]                    trial;
	logic [CNT_W-1:0]                  diff;
	logic [CNT_W-1:0]                  rem_nxt;

	always_comb begin
		trial   = {rem_q, quo_q[rpst_pkg::RND_W-1]};
		// taken only when trial >= divisor, so the difference fits below divisor
		diff    = trial[CNT_W-1:0] - divisor;
		rem_nxt = (trial >= {1'b0, divisor}) ? diff : trial[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (run_q) begin
			step_q <= step_q + rpst_pkg::STEP_W'(1);
			if (step_q == rpst_pkg::STEP_W'(rpst_pkg::RND_W - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[rpst_pkg::RND_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	// remainder stays below divisor, so it fits an index
	assign done      = done_q;
	assign remainder = rem_q[IDX_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/rpst_chk.sv =====
// rpst_chk: port-level checks for random_pick_set_table.
// Bound to the top level below; uses rpst_pkg status codes.
`default_nettype none

module rpst_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic               done,
	input wire logic               success,
	input wire logic signed [31:0] picked_value,
	input wire logic [1:0]         status
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe not at end of busy period");

	a_success_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (success == (status == rpst_pkg::ST_DONE)))
		else $error("success and status disagree");

	a_fail_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && !success |-> picked_value == 32'sd0)
		else $error("failed item returned a value");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule

bind random_pick_set_table rpst_chk u_rpst_chk (.*);

`default_nettype wire
